/* hw/rtl/singular_values_2x2_defines.svh */
// Assertion macros for the singular_values_2x2 block.
// Expects signals named clock and reset in the including module.
`ifndef SINGULAR_VALUES_2X2_DEFINES_SVH
`define SINGULAR_VALUES_2X2_DEFINES_SVH

// same-cycle implication
`define SV2_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("singular_values_2x2 assertion failed");

// next-cycle implication
`define SV2_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("singular_values_2x2 assertion failed");

`endif

/* hw/rtl/sv2_pkg.sv */
// Shared types and constants for the 2x2 singular value block.
// No dependencies.
package sv2_pkg;

   // pipeline control handed to every root cell
   typedef struct packed {
      logic adv;
   } pipe_ctl_type;

   // low bits of the trial value 4*root+1 in one root digit step
   localparam logic [1:0] TRIAL_TAIL = 2'b01;

endpackage

/* hw/rtl/sv2_cell.sv */
// One digit step of a pipelined floor square root, for LANES lanes at once.
// Depends on sv2_pkg.
module sv2_cell #(
   parameter int ROOT_BITS = 17,
   parameter int LANES     = 1
) (
   input  logic                           clock,
   input  sv2_pkg::pipe_ctl_type          ctl,
   input  logic [LANES*2*ROOT_BITS-1:0]   rad_in,
   input  logic [LANES*(ROOT_BITS+2)-1:0] rem_in,
   input  logic [LANES*ROOT_BITS-1:0]     root_in,
   output logic [LANES*2*ROOT_BITS-1:0]   rad_out,
   output logic [LANES*(ROOT_BITS+2)-1:0] rem_out,
   output logic [LANES*ROOT_BITS-1:0]     root_out
);
   import sv2_pkg::*;

   localparam int XW = 2 * ROOT_BITS;
   localparam int RW = ROOT_BITS + 2;

   logic [RW-1:0]              rem_sh [LANES];
   logic [RW-1:0]              trial  [LANES];
   logic [LANES*XW-1:0]        rad_ff, rad_in_nxt;
   logic [LANES*RW-1:0]        rem_ff, rem_nxt;
   logic [LANES*ROOT_BITS-1:0] root_ff, root_nxt;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         // bring down the next two radicand bits
         rem_sh[l] = {rem_in[l*RW +: ROOT_BITS], rad_in[l*XW + XW - 2 +: 2]};
         trial[l]  = {root_in[l*ROOT_BITS +: ROOT_BITS], TRIAL_TAIL};
         rad_in_nxt[l*XW +: XW] = {rad_in[l*XW +: XW-2], 2'b00};
         if (rem_sh[l] >= trial[l]) begin
            rem_nxt[l*RW +: RW] = rem_sh[l] - trial[l];
            root_nxt[l*ROOT_BITS +: ROOT_BITS] =
               {root_in[l*ROOT_BITS +: ROOT_BITS-1], 1'b1};
         end else begin
            rem_nxt[l*RW +: RW] = rem_sh[l];
            root_nxt[l*ROOT_BITS +: ROOT_BITS] =
               {root_in[l*ROOT_BITS +: ROOT_BITS-1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         rad_ff  <= rad_in_nxt;
         rem_ff  <= rem_nxt;
         root_ff <= root_nxt;
      end
   end

   assign rad_out  = rad_ff;
   assign rem_out  = rem_ff;
   assign root_out = root_ff;

endmodule

/* hw/rtl/singular_values_2x2.sv */
// Closed-form singular values of a real 2x2 matrix, one item per unstalled clock.
// Depends on sv2_pkg, sv2_cell and singular_values_2x2_defines.svh.
//
// Each item is a 2x2 matrix of signed fixed-point elements; the result is the
// pair of singular values, larger first, floor rounded, with the same number of
// fraction bits as the elements (the fraction count does not change the
// integer datapath, so it is not a parameter here). The block takes one item
// every cycle while not held, through 3*ELEM_WIDTH+7 register stages (55 at
// the default width): four front stages (squares and cross products, sum and
// |det|, the two wide squares, the discriminant), a chain of 2*ELEM_WIDTH+1
// root cells for sqrt(s*s-4*det^2), one stage forming (s+root)/2 and
// (s-root)/2, then ELEM_WIDTH+1 dual-lane root cells that finish both
// singular values side by side. The whole pipe advances together; it
// holds only while a result waits at the output with rsp_stall high, so the
// input is stalled in exactly those cycles. The last flag rides along.
module singular_values_2x2 #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ELEM_WIDTH-1:0] req_elem_row0_col0,
   input  logic [ELEM_WIDTH-1:0] req_elem_row1_col0,
   input  logic [ELEM_WIDTH-1:0] req_elem_row0_col1,
   input  logic [ELEM_WIDTH-1:0] req_elem_row1_col1,
   input  logic                  req_last_matrix,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [ELEM_WIDTH:0]   rsp_larger_value,
   output logic [ELEM_WIDTH:0]   rsp_smaller_value,
   output logic                  rsp_last_result
);
   import sv2_pkg::*;
`include "singular_values_2x2_defines.svh"

   localparam int E     = ELEM_WIDTH;
   localparam int SW    = 2*E + 1;        // sum of squares
   localparam int MW    = 2*E;            // |det|
   localparam int DW    = 4*E + 2;        // discriminant
   localparam int N1    = 2*E + 1;        // root bits of discriminant
   localparam int N2    = E + 1;          // root bits of singular values
   localparam int DEPTH = 4 + N1 + 1 + N2;

   pipe_ctl_type ctl;
   logic         adv;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic [DEPTH-1:0] last_ff, last_in;

   // front stage A: element products
   logic signed [E-1:0]   ea, eb, ec, ed;
   logic signed [2*E-1:0] aa_in, bb_in, cc_in, dd_in, ad_in, bc_in;
   logic [2*E-1:0]        aa_ff, bb_ff, cc_ff, dd_ff, ad_ff, bc_ff;
   // stage B: sum of squares and |det|
   logic [SW-1:0] s_b_in, s_b_ff;
   logic [2*E:0]  det;
   logic [MW-1:0] mag_in, mag_ff;
   // stage C: wide squares
   logic [DW-1:0]  ss_in, ss_ff;
   logic [4*E-1:0] qq_in, qq_ff;
   logic [SW-1:0]  s_c_ff;
   // stage D: discriminant
   logic [DW-1:0] disc_in, disc_ff;
   logic [SW-1:0] s_d_ff;
   // s rides beside the first root chain
   logic [SW-1:0] s_chain_ff [N1];
   logic [SW-1:0] s_chain_in [N1];
   // stage E: half sums
   logic [SW:0]     sum_full;
   logic [SW-1:0]   diff, hi, lo;
   logic [4*N2-1:0] half_in, half_ff;

   logic [2*N1-1:0] c1_rad  [N1+1];
   logic [N1+1:0]   c1_rem  [N1+1];
   logic [N1-1:0]   c1_root [N1+1];
   logic [4*N2-1:0] c2_rad  [N2+1];
   logic [2*N2+3:0] c2_rem  [N2+1];
   logic [2*N2-1:0] c2_root [N2+1];

   // whole pipe moves unless a finished item is held at the output
   assign adv       = !(vld_ff[DEPTH-1] && rsp_stall);
   assign ctl.adv   = adv;
   assign req_stall = !adv;

   assign vld_in  = {vld_ff[DEPTH-2:0], req_valid};
   assign last_in = {last_ff[DEPTH-2:0], req_last_matrix};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         last_ff <= last_in;
      end
   end

   // stage A
   assign ea = req_elem_row0_col0;
   assign ec = req_elem_row1_col0;
   assign eb = req_elem_row0_col1;
   assign ed = req_elem_row1_col1;

   always_comb begin
      aa_in = ea * ea;
      bb_in = eb * eb;
      cc_in = ec * ec;
      dd_in = ed * ed;
      ad_in = ea * ed;
      bc_in = eb * ec;
   end

   // stage B
   always_comb begin
      s_b_in = SW'(aa_ff) + SW'(bb_ff) + SW'(cc_ff) + SW'(dd_ff);
      det    = {ad_ff[2*E-1], ad_ff} - {bc_ff[2*E-1], bc_ff};
      mag_in = det[2*E] ? MW'(~det + 1'b1) : MW'(det);
   end

   // stage C and D
   assign ss_in   = s_b_ff * s_b_ff;
   assign qq_in   = mag_ff * mag_ff;
   assign disc_in = ss_ff - {qq_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (adv) begin
         aa_ff   <= aa_in;
         bb_ff   <= bb_in;
         cc_ff   <= cc_in;
         dd_ff   <= dd_in;
         ad_ff   <= ad_in;
         bc_ff   <= bc_in;
         s_b_ff  <= s_b_in;
         mag_ff  <= mag_in;
         ss_ff   <= ss_in;
         qq_ff   <= qq_in;
         s_c_ff  <= s_b_ff;
         disc_ff <= disc_in;
         s_d_ff  <= s_c_ff;
      end
   end

   // first root chain: sqrt of the discriminant
   assign c1_rad[0]  = disc_ff;
   assign c1_rem[0]  = '0;
   assign c1_root[0] = '0;

   for (genvar i = 0; i < N1; i++) begin : g_chain1
      sv2_cell #(.ROOT_BITS(N1), .LANES(1)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .rad_in   (c1_rad[i]),
         .rem_in   (c1_rem[i]),
         .root_in  (c1_root[i]),
         .rad_out  (c1_rad[i+1]),
         .rem_out  (c1_rem[i+1]),
         .root_out (c1_root[i+1])
      );
   end

   always_comb begin
      s_chain_in[0] = s_d_ff;
      for (int i = 1; i < N1; i++) begin
         s_chain_in[i] = s_chain_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_chain_ff <= s_chain_in;
      end
   end

   // stage E: (s +/- root) / 2, root never exceeds s
   always_comb begin
      sum_full = {1'b0, s_chain_ff[N1-1]} + {1'b0, c1_root[N1]};
      diff     = s_chain_ff[N1-1] - c1_root[N1];
      hi       = sum_full[SW:1];
      lo       = {1'b0, diff[SW-1:1]};
      half_in  = {1'b0, lo, 1'b0, hi};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         half_ff <= half_in;
      end
   end

   // second root chain: lane 0 larger, lane 1 smaller
   assign c2_rad[0]  = half_ff;
   assign c2_rem[0]  = '0;
   assign c2_root[0] = '0;

   for (genvar i = 0; i < N2; i++) begin : g_chain2
      sv2_cell #(.ROOT_BITS(N2), .LANES(2)) u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .rad_in   (c2_rad[i]),
         .rem_in   (c2_rem[i]),
         .root_in  (c2_root[i]),
         .rad_out  (c2_rad[i+1]),
         .rem_out  (c2_rem[i+1]),
         .root_out (c2_root[i+1])
      );
   end

   assign rsp_valid         = vld_ff[DEPTH-1];
   assign rsp_last_result   = last_ff[DEPTH-1];
   assign rsp_larger_value  = c2_root[N2][N2-1:0];
   assign rsp_smaller_value = c2_root[N2][2*N2-1:N2];

   // ordering of the two results
   `SV2_ASSERT_NOW(a_order, rsp_valid, rsp_smaller_value <= rsp_larger_value)
   // discriminant never goes negative
   `SV2_ASSERT_NOW(a_disc_sign, vld_ff[3], !disc_ff[DW-1])
   // a held pipe keeps its occupancy
   `SV2_ASSERT_NEXT(a_hold, !adv, $stable(vld_ff))

endmodule

/* tb/sv/sv2_checker.sv */
// Checker for singular_values_2x2: watches both channels, predicts each result
// from the accepted matrix and compares it field by field. Needs no package.
`timescale 1ns / 100ps
module sv2_checker #(
   parameter int ELEM_WIDTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [ELEM_WIDTH-1:0] req_elem_row0_col0,
   input  logic [ELEM_WIDTH-1:0] req_elem_row1_col0,
   input  logic [ELEM_WIDTH-1:0] req_elem_row0_col1,
   input  logic [ELEM_WIDTH-1:0] req_elem_row1_col1,
   input  logic                  req_last_matrix,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [ELEM_WIDTH:0]   rsp_larger_value,
   input  logic [ELEM_WIDTH:0]   rsp_smaller_value,
   input  logic                  rsp_last_result,
   output int                    fail_count,
   output int                    pending_count,
   output int                    result_count
);

   typedef struct packed {
      logic [ELEM_WIDTH:0] larger;
      logic [ELEM_WIDTH:0] smaller;
      logic                last;
   } sv_pair_type;

   sv_pair_type expected_pairs[$];

   // floor sqrt of a 128-bit value, bit by bit
   function automatic logic [63:0] floor_root(logic [127:0] x);
      logic [63:0]  r;
      logic [63:0]  c;
      r = '0;
      for (int bit_i = 63; bit_i >= 0; bit_i--) begin
         c = r | (64'd1 << bit_i);
         if ({64'd0, c} * {64'd0, c} <= x) r = c;
      end
      return r;
   endfunction

   function automatic sv_pair_type predict_pair(logic [ELEM_WIDTH-1:0] ea,
                                                logic [ELEM_WIDTH-1:0] ec,
                                                logic [ELEM_WIDTH-1:0] eb,
                                                logic [ELEM_WIDTH-1:0] ed,
                                                logic lst);
      logic signed [63:0] a, b, c, d, det;
      logic [127:0]       s, mag, disc;
      logic [63:0]        root;
      sv_pair_type        p;
      a = 64'(signed'(ea));
      b = 64'(signed'(eb));
      c = 64'(signed'(ec));
      d = 64'(signed'(ed));
      s = 128'(a * a + b * b + c * c + d * d);
      det = a * d - b * c;
      mag = 128'(det < 0 ? -det : det);
      disc = s * s - 4 * mag * mag;
      root = floor_root(disc);
      if (128'(root) > s) root = s[63:0];
      p.larger  = (ELEM_WIDTH+1)'(floor_root((s + 128'(root)) >> 1));
      p.smaller = (ELEM_WIDTH+1)'(floor_root((s - 128'(root)) >> 1));
      p.last    = lst;
      return p;
   endfunction

   assign pending_count = expected_pairs.size();

   always @(posedge clock) begin
      sv_pair_type want;
      if (reset) begin
         fail_count   <= 0;
         result_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_pairs.push_back(predict_pair(req_elem_row0_col0, req_elem_row1_col0,
                                     req_elem_row0_col1, req_elem_row1_col1, req_last_matrix));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_pairs.size() == 0) begin
               if (fail_count < 10) $display("unexpected result at %0t", $time);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pairs.pop_front();
               if (want.larger !== rsp_larger_value || want.smaller !== rsp_smaller_value ||
                   want.last !== rsp_last_result) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %0d %0d %0b got %0d %0d %0b", want.larger,
                              want.smaller, want.last, rsp_larger_value, rsp_smaller_value,
                              rsp_last_result);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* tb/sv/tb.sv */
// Top testbench for singular_values_2x2: drives matrices in bursts, stalls
// the output on its own pattern, gives the verdict. Depends on sv2_checker.
`timescale 1ns / 100ps
module tb;

   localparam int EW         = 16;
   localparam int RAND_ITEMS = 1550;
   localparam int LATENCY    = 3 * EW + 7;
   localparam int CYCLE_CAP  = 200000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_valid = 0;
   logic          req_stall;
   logic [EW-1:0] m_a = 0, m_c = 0, m_b = 0, m_d = 0;
   logic          m_last = 0;
   logic          rsp_valid;
   logic          rsp_stall = 0;
   logic [EW:0]   rsp_larger_value, rsp_smaller_value;
   logic          rsp_last_result;
   int            fail_count, pending_count, result_count;
   int            cycle_count = 0;
   int            stall_mode = 0;

   initial forever #6 clock = ~clock;

   singular_values_2x2 #(.ELEM_WIDTH(EW)) DUT (
      .clock, .reset, .req_valid, .req_stall,
      .req_elem_row0_col0(m_a), .req_elem_row1_col0(m_c),
      .req_elem_row0_col1(m_b), .req_elem_row1_col1(m_d),
      .req_last_matrix(m_last),
      .rsp_valid, .rsp_stall, .rsp_larger_value, .rsp_smaller_value, .rsp_last_result
   );

   sv2_checker #(.ELEM_WIDTH(EW)) u_checker (
      .clock, .reset, .req_valid, .req_stall,
      .req_elem_row0_col0(m_a), .req_elem_row1_col0(m_c),
      .req_elem_row0_col1(m_b), .req_elem_row1_col1(m_d),
      .req_last_matrix(m_last),
      .rsp_valid, .rsp_stall, .rsp_larger_value, .rsp_smaller_value, .rsp_last_result,
      .fail_count, .pending_count, .result_count
   );

   // watchdog: far beyond the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver stall: switches among free flow, light, heavy and long-hold patterns
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   // element pick: extremes often, small values, else fully random
   function automatic logic [EW-1:0] pick_elem();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return EW'($urandom_range(0, 15) - 8);
         default: return EW'($urandom);
      endcase
   endfunction

   // present one item and hold it until accepted
   task automatic send_matrix(logic [EW-1:0] a, logic [EW-1:0] c, logic [EW-1:0] b,
                              logic [EW-1:0] d, logic lst);
      req_valid <= 1'b1;
      m_a <= a; m_c <= c; m_b <= b; m_d <= d; m_last <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic rest(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int burst;
      int sent;
      logic [EW-1:0] ra, rb;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zero, extremes, singular matrices, identity-like, last flag
      send_matrix('0, '0, '0, '0, 1'b0);
      send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_matrix(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0);
      send_matrix(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b1);
      send_matrix(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 1'b0);
      send_matrix(16'h0100, '0, '0, 16'h0100, 1'b1);
      send_matrix(16'h0100, 16'h0200, 16'h0200, 16'h0400, 1'b0);
      send_matrix(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      send_matrix(16'h8000, '0, '0, '0, 1'b0);
      send_matrix('0, '0, '0, 16'h7fff, 1'b1);
      send_matrix(16'h8000, '0, '0, 16'h8000, 1'b0);
      send_matrix(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 1'b1);
      send_matrix(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1'b0);
      send_matrix(16'h0001, '0, 16'h0001, '0, 1'b1);
      rest(3);
      // random: bursts with gaps, some matrices deliberately singular
      sent = 0;
      while (sent < RAND_ITEMS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            ra = pick_elem();
            rb = pick_elem();
            if ($urandom_range(0, 5) == 0)
               send_matrix(ra, rb, ra, rb, 1'($urandom_range(0, 1)));
            else
               send_matrix(ra, pick_elem(), rb, pick_elem(), 1'($urandom_range(0, 1)));
            sent++;
         end
         if ($urandom_range(0, 2) != 0) rest($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d matrices with extreme, singular and random elements", sent + 14);
      $display("%0d results checked under bursty input and patterned output stall",
               result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sv2_pkg.sv
hw/rtl/sv2_cell.sv
hw/rtl/singular_values_2x2.sv
tb/sv/sv2_checker.sv
tb/sv/tb.sv
